>>> hw/rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define MALU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion, also checked during reset
`define MALU_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/malu_pkg.sv
// package with shared types and codes of the special alu
package malu_pkg;

  typedef enum logic [3:0] {
    OP_SLL  = 4'd0,
    OP_SRL  = 4'd1,
    OP_SRA  = 4'd2,
    OP_AND  = 4'd3,
    OP_OR   = 4'd4,
    OP_ADDU = 4'd5,
    OP_ADD  = 4'd6,
    OP_SUBU = 4'd7,
    OP_SLT  = 4'd8,
    OP_SLTU = 4'd9,
    OP_JR   = 4'd10,
    OP_JALR = 4'd11,
    OP_DIV  = 4'd12,
    OP_DIVU = 4'd13,
    OP_MFHI = 4'd14,
    OP_MFLO = 4'd15
  } op_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_OVF  = 2'd1;
  localparam logic [1:0] STATUS_DIVZ = 2'd2;

  localparam logic [31:0] INT_MIN_WORD = 32'h8000_0000;
  localparam logic [31:0] WORD_MASK    = 32'hffff_ffff;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } state_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_enable;
    logic        take_jump;
    logic [31:0] jump_target;
    logic [1:0]  status;
  } res_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

endpackage

>>> hw/rtl/mips_special_alu_hilo_divide.sv
// top level of the mips special-class alu with hi/lo divider
//
// channel | direction | tdata                                         | tuser
// in_     | slave     | src_a, src_b, shift_amount, link_address      | op
// out_    | master    | result, jump_target                           | write_enable, take_jump, status
//
// non-divide transactions and divides by zero: registered result, one per cycle while out_ drains
// divides: the shared restoring divider works through all 32 quotient bits, then the result waits for out_ to be free
// in_tready is low during a divide and while a finished result waits on out_tready
// rst_n clears hi, lo, the sequencer and the output valid
module mips_special_alu_hilo_divide (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,  // src_a, src_b, shift_amount, link_address, zero pad
  input  logic [3:0]   in_tuser,  // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // result, jump_target
  output logic [3:0]   out_tuser  // write_enable, take_jump, status
);

  malu_pkg::state_t   state_r, state_nxt;
  malu_pkg::res_t     alu_res;
  malu_pkg::res_t     out_res_r, out_res_nxt;
  malu_pkg::div_req_t div_req;
  malu_pkg::div_rsp_t div_rsp;
  logic               out_valid_r, out_valid_nxt;
  logic [31:0]        hi_r, hi_nxt;
  logic [31:0]        lo_r, lo_nxt;
  logic               neg_q_r, neg_q_nxt;
  logic               neg_r_r, neg_r_nxt;
  logic [3:0]         op;
  logic [31:0]        src_a, src_b, link_address;
  logic [4:0]         shift_amount;
  logic               out_free;
  logic               accept;
  logic               is_div, is_divu, sgn;
  logic [31:0]        mag_a, mag_b;

  assign op = in_tuser;
  assign src_a = in_tdata[31:0];
  assign src_b = in_tdata[63:32];
  assign shift_amount = in_tdata[68:64];
  assign link_address = in_tdata[100:69];

  malu_alu u_alu (
    .op           (op),
    .src_a        (src_a),
    .src_b        (src_b),
    .shift_amount (shift_amount),
    .link_address (link_address),
    .hi           (hi_r),
    .lo           (lo_r),
    .res          (alu_res)
  );

  malu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == malu_pkg::ST_IDLE) && out_free;
  assign accept = in_tvalid && in_tready;
  assign is_div = (op == malu_pkg::OP_DIV);
  assign is_divu = (op == malu_pkg::OP_DIVU);
  assign sgn = is_div;
  assign mag_a = (sgn && src_a[31]) ? (~src_a + 32'd1) : src_a;
  assign mag_b = (sgn && src_b[31]) ? (~src_b + 32'd1) : src_b;

  always_comb begin
    state_nxt = state_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt = out_res_r;
    hi_nxt = hi_r;
    lo_nxt = lo_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    div_req.start = 1'b0;
    div_req.dividend = mag_a;
    div_req.divisor = mag_b;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      malu_pkg::ST_IDLE: begin
        if (accept) begin
          if ((is_div || is_divu) && (src_b != '0)) begin
            div_req.start = 1'b1;
            neg_q_nxt = sgn && (src_a[31] ^ src_b[31]);
            neg_r_nxt = sgn && src_a[31];
            state_nxt = malu_pkg::ST_DIV;
          end else begin
            out_valid_nxt = 1'b1;
            out_res_nxt = alu_res;
            if (is_div || is_divu) begin
              hi_nxt = src_a;
              lo_nxt = (is_div && src_a[31]) ? 32'd1 : malu_pkg::WORD_MASK;
            end
          end
        end
      end
      malu_pkg::ST_DIV: begin
        if (div_rsp.done && out_free) begin
          lo_nxt = neg_q_r ? (~div_rsp.quotient + 32'd1) : div_rsp.quotient;
          hi_nxt = neg_r_r ? (~div_rsp.remainder + 32'd1) : div_rsp.remainder;
          out_valid_nxt = 1'b1;
          out_res_nxt = '0;
          out_res_nxt.status = malu_pkg::STATUS_OK;
          state_nxt = malu_pkg::ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= malu_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      hi_r <= '0;
      lo_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
      hi_r <= hi_nxt;
      lo_r <= lo_nxt;
    end
    out_res_r <= out_res_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_res_r.jump_target, out_res_r.result};
  assign out_tuser = {out_res_r.status, out_res_r.take_jump, out_res_r.write_enable};

endmodule

>>> hw/rtl/malu_alu.sv
// combinational operations and result formatting
module malu_alu (
  input  logic [3:0]       op,
  input  logic [31:0]      src_a,
  input  logic [31:0]      src_b,
  input  logic [4:0]       shift_amount,
  input  logic [31:0]      link_address,
  input  logic [31:0]      hi,
  input  logic [31:0]      lo,
  output malu_pkg::res_t   res
);

  logic [31:0] sum;
  logic        ovf;

  assign sum = src_a + src_b;
  assign ovf = (src_a[31] == src_b[31]) && (sum[31] != src_a[31]);

  always_comb begin
    res = '0;
    res.write_enable = 1'b1;
    res.status = malu_pkg::STATUS_OK;
    unique case (malu_pkg::op_t'(op))
      malu_pkg::OP_SLL:  res.result = src_b << shift_amount;
      malu_pkg::OP_SRL:  res.result = src_b >> shift_amount;
      malu_pkg::OP_SRA:  res.result = $unsigned($signed(src_b) >>> shift_amount);
      malu_pkg::OP_AND:  res.result = src_a & src_b;
      malu_pkg::OP_OR:   res.result = src_a | src_b;
      malu_pkg::OP_ADDU: res.result = sum;
      malu_pkg::OP_ADD: begin
        if (ovf) begin
          res.write_enable = 1'b0;
          res.status = malu_pkg::STATUS_OVF;
        end else begin
          res.result = sum;
        end
      end
      malu_pkg::OP_SUBU: res.result = src_a - src_b;
      malu_pkg::OP_SLT:  res.result = {31'd0, $signed(src_a) < $signed(src_b)};
      malu_pkg::OP_SLTU: res.result = {31'd0, src_a < src_b};
      malu_pkg::OP_JR: begin
        res.write_enable = 1'b0;
        res.take_jump = 1'b1;
        res.jump_target = src_a;
      end
      malu_pkg::OP_JALR: begin
        res.result = link_address;
        res.take_jump = 1'b1;
        res.jump_target = src_a;
      end
      malu_pkg::OP_DIV, malu_pkg::OP_DIVU: begin
        res.write_enable = 1'b0;
        if (src_b == '0) begin
          res.status = malu_pkg::STATUS_DIVZ;
        end
      end
      malu_pkg::OP_MFHI: res.result = hi;
      malu_pkg::OP_MFLO: res.result = lo;
    endcase
  end

endmodule

>>> hw/rtl/malu_div.sv
// radix-2 restoring divider, one quotient bit per cycle
module malu_div (
  input  logic                clk,
  input  logic                rst_n,
  input  malu_pkg::div_req_t  req,
  output malu_pkg::div_rsp_t  rsp
);

  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] diff;

  assign diff = {1'b0, rem_r, quo_r[31]} - {2'b00, dvs_r};

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (diff[33]) begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end else begin
        rem_nxt = diff[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
  assign rsp.remainder = rem_r;

endmodule

>>> hw/rtl/malu_checker.sv
// port-level checker for the special alu, bound to the top level
`include "assert_macros.svh"

module malu_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [3:0]   in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [3:0]   out_tuser
);

  `MALU_ASSERT_RST(a_reset_clears_out, !rst_n |=> !out_tvalid, "out_tvalid after reset")
  `MALU_ASSERT(a_out_holds, out_tvalid && !out_tready |=> out_tvalid, "result dropped on stall")
  `MALU_ASSERT(a_no_write_zero, out_tvalid && !out_tuser[0] |-> out_tdata[31:0] == 32'd0, "result not zero without write")
  `MALU_ASSERT(a_jump_ok, out_tvalid && out_tuser[1] |-> out_tuser[3:2] == malu_pkg::STATUS_OK, "jump with bad status")
  `MALU_ASSERT(a_fast_op_done, in_tvalid && in_tready && in_tuser != malu_pkg::OP_DIV && in_tuser != malu_pkg::OP_DIVU |=> out_tvalid, "single-cycle transaction lost")

endmodule

bind mips_special_alu_hilo_divide malu_checker u_malu_checker (.*);
